[sv/fpp_pkg.sv]
// Shared types, constants and helper functions for the fisheye point projector.
`timescale 1ns / 1ps
package fpp_pkg;

  // Sizes
  localparam int MAX_POLY_TERMS_DEF = 16;
  localparam int T_ENTRIES          = 12;
  localparam int QUEUE_DEPTH        = 2;
  localparam int CORDIC_STEPS       = 30;

  localparam logic [30:0] HALF_PI_Q29 = 31'd843314857;

  // Request function codes
  localparam logic [1:0] FUNC_PROJECT = 2'd0;
  localparam logic [1:0] FUNC_LOAD_T  = 2'd1;
  localparam logic [1:0] FUNC_LOAD_C  = 2'd2;

  // Queue operation codes
  localparam logic [1:0] OP_PROJECT = 2'd0;
  localparam logic [1:0] OP_LOAD_T  = 2'd1;
  localparam logic [1:0] OP_LOAD_C  = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_HALF_FOV   = 3'd0;
  localparam logic [2:0] REG_CENTER_ROW = 3'd1;
  localparam logic [2:0] REG_CENTER_COL = 3'd2;
  localparam logic [2:0] REG_AFFINE_C   = 3'd3;
  localparam logic [2:0] REG_AFFINE_D   = 3'd4;
  localparam logic [2:0] REG_AFFINE_E   = 3'd5;
  localparam logic [2:0] REG_POLY_TERMS = 3'd6;

  // Register reset values
  localparam logic [30:0] RST_HALF_FOV   = 31'd843314857;
  localparam logic [31:0] RST_AFFINE_C   = 32'd16777216;
  localparam logic [4:0]  RST_POLY_TERMS = 5'd1;

  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         idx;
    logic signed [47:0] value;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } qent_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic [4:0]         shamt;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] res;
  } mul_rsp_t;

  typedef struct packed {
    logic [30:0]        half_fov;
    logic [31:0]        center_row;
    logic [31:0]        center_col;
    logic signed [31:0] affine_c;
    logic signed [31:0] affine_d;
    logic signed [31:0] affine_e;
    logic [4:0]         poly_terms;
  } cfg_t;

  // atan(2^-i) in Q3.29
  function automatic logic [28:0] atan_entry(input logic [4:0] i);
    logic [28:0] v;
    case (i)
      5'd0:  v = 29'd421657428;
      5'd1:  v = 29'd248918915;
      5'd2:  v = 29'd131521918;
      5'd3:  v = 29'd66762579;
      5'd4:  v = 29'd33510843;
      5'd5:  v = 29'd16771758;
      5'd6:  v = 29'd8387925;
      5'd7:  v = 29'd4194219;
      5'd8:  v = 29'd2097141;
      5'd9:  v = 29'd1048575;
      5'd10: v = 29'd524288;
      5'd11: v = 29'd262144;
      5'd12: v = 29'd131072;
      5'd13: v = 29'd65536;
      5'd14: v = 29'd32768;
      5'd15: v = 29'd16384;
      5'd16: v = 29'd8192;
      5'd17: v = 29'd4096;
      5'd18: v = 29'd2048;
      5'd19: v = 29'd1024;
      5'd20: v = 29'd512;
      5'd21: v = 29'd256;
      5'd22: v = 29'd128;
      5'd23: v = 29'd64;
      5'd24: v = 29'd32;
      5'd25: v = 29'd16;
      5'd26: v = 29'd8;
      5'd27: v = 29'd4;
      5'd28: v = 29'd2;
      5'd29: v = 29'd1;
      default: v = 29'd0;
    endcase
    return v;
  endfunction

  // Saturate a 64 bit value to 32 bit signed
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh000000007FFFFFFF) r = 32'sh7FFFFFFF;
    else if (v < -64'sh0000000080000000) r = -32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Saturate a 65 bit value to 48 bit signed
  function automatic logic signed [47:0] sat48(input logic signed [64:0] v);
    logic signed [47:0] r;
    if (v > 65'sh00007FFFFFFFFFFF) r = 48'sh7FFFFFFFFFFF;
    else if (v < -65'sh0000800000000000) r = -48'sh800000000000;
    else r = v[47:0];
    return r;
  endfunction

endpackage

[sv/fpp_front.sv]
// Front end: accepts requests and classifies them for the work queue.
`timescale 1ns / 1ps
module fpp_front import fpp_pkg::*; #(
  parameter int MAX_POLY_TERMS = MAX_POLY_TERMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic [3:0]         in_load_index,
  input  logic signed [47:0] in_load_value,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  input  logic               q_full,
  output logic               q_push,
  output qent_t              q_ent
);

  logic keep;
  logic accept;

  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;

  // Out-of-range loads and the unused code are taken and dropped here
  always_comb begin
    keep     = 1'b0;
    q_ent.op = OP_PROJECT;
    case (in_func)
      FUNC_PROJECT: begin
        keep     = 1'b1;
        q_ent.op = OP_PROJECT;
      end
      FUNC_LOAD_T: begin
        keep     = (in_load_index < 4'(T_ENTRIES));
        q_ent.op = OP_LOAD_T;
      end
      FUNC_LOAD_C: begin
        keep     = ({28'd0, in_load_index} < 32'(MAX_POLY_TERMS));
        q_ent.op = OP_LOAD_C;
      end
      default: begin
        keep     = 1'b0;
        q_ent.op = OP_PROJECT;
      end
    endcase
  end

  assign q_ent.idx   = in_load_index;
  assign q_ent.value = in_load_value;
  assign q_ent.x     = in_point_x;
  assign q_ent.y     = in_point_y;
  assign q_ent.z     = in_point_z;
  assign q_ent.red   = in_red;
  assign q_ent.green = in_green;
  assign q_ent.blue  = in_blue;

  assign q_push = accept & keep;

  // A push is only ever made into a queue with room
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("push into full queue");

  a_drop_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_func != FUNC_PROJECT && in_func != FUNC_LOAD_T &&
     in_func != FUNC_LOAD_C) |-> !q_push) else $error("unused code queued");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && in_func == FUNC_LOAD_T) |-> in_load_index < 4'(T_ENTRIES))
    else $error("bad transform index queued");

endmodule

[sv/fpp_queue.sv]
// Short request queue between the front end and the back end.
`timescale 1ns / 1ps
module fpp_queue import fpp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_ent,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output qent_t head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  qent_t             mem_r [0:QUEUE_DEPTH-1];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;

  assign full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_ent;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> valid) else $error("pop from empty queue");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");

  a_push_pop_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("count slip");

endmodule

[sv/fpp_mul.sv]
// Shared multi-cycle multiplier: floor(a*b / 2^s), saturated to 64 bit signed.
`timescale 1ns / 1ps
module fpp_mul import fpp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_PP   = 2'd1;
  localparam logic [1:0] M_NEG  = 2'd2;
  localparam logic [1:0] M_FIN  = 2'd3;

  logic [1:0]          st_r;
  logic [1:0]          cnt_r;
  logic [63:0]         ua_r;
  logic [63:0]         ub_r;
  logic                neg_r;
  logic [4:0]          sh_r;
  logic [127:0]        prod_r;
  logic signed [63:0]  res_r;
  logic                done_r;

  logic [31:0]         a_sel;
  logic [31:0]         b_sel;
  logic [63:0]         pp;
  logic [127:0]        pp_sh;
  logic signed [127:0] shd;
  logic                fits;

  // One 32x32 partial product per cycle
  assign a_sel = cnt_r[1] ? ua_r[63:32] : ua_r[31:0];
  assign b_sel = cnt_r[0] ? ub_r[63:32] : ub_r[31:0];
  assign pp    = a_sel * b_sel;

  always_comb begin
    case (cnt_r)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  assign shd  = $signed(prod_r) >>> sh_r;
  assign fits = (&shd[127:63]) | ~(|shd[127:63]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= M_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        M_IDLE: begin
          if (req.start) begin
            ua_r   <= req.a[63] ? 64'(-req.a) : 64'(req.a);
            ub_r   <= req.b[63] ? 64'(-req.b) : 64'(req.b);
            neg_r  <= req.a[63] ^ req.b[63];
            sh_r   <= req.shamt;
            prod_r <= '0;
            cnt_r  <= '0;
            st_r   <= M_PP;
          end
        end
        M_PP: begin
          prod_r <= prod_r + pp_sh;
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == 2'd3) st_r <= M_NEG;
        end
        M_NEG: begin
          if (neg_r) prod_r <= ~prod_r + 128'd1;
          st_r <= M_FIN;
        end
        M_FIN: begin
          if (fits) res_r <= shd[63:0];
          else res_r <= prod_r[127] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
          done_r <= 1'b1;
          st_r   <= M_IDLE;
        end
        default: st_r <= M_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> st_r == M_IDLE) else $error("multiplier started while busy");

  a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(st_r) == M_FIN) else $error("stray multiplier done");

  a_fin_from_neg: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == M_FIN |-> $past(st_r) == M_NEG) else $error("multiplier sequence slip");

endmodule

[sv/fpp_back.sv]
// Back end: stores, transform, norm, angle, polynomial, ratios and pixel output.
`timescale 1ns / 1ps
module fpp_back import fpp_pkg::*; #(
  parameter int MAX_POLY_TERMS = MAX_POLY_TERMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  qent_t              q_head,
  output logic               q_pop,
  input  cfg_t               cfg,
  output mul_req_t           mreq,
  input  mul_rsp_t           mrsp,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_row_pos,
  output logic signed [31:0] out_col_pos,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue
);

  localparam int CA_W  = $clog2(MAX_POLY_TERMS);
  localparam int CNT_W = $clog2(MAX_POLY_TERMS + 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_TADDR = 5'd1;
  localparam logic [4:0] S_TWAIT = 5'd2;
  localparam logic [4:0] S_TUSE  = 5'd3;
  localparam logic [4:0] S_TMUL  = 5'd4;
  localparam logic [4:0] S_TROW  = 5'd5;
  localparam logic [4:0] S_CHK   = 5'd6;
  localparam logic [4:0] S_SQY   = 5'd7;
  localparam logic [4:0] S_SQZ   = 5'd8;
  localparam logic [4:0] S_SQRT  = 5'd9;
  localparam logic [4:0] S_NORMI = 5'd10;
  localparam logic [4:0] S_NORM  = 5'd11;
  localparam logic [4:0] S_CORD  = 5'd12;
  localparam logic [4:0] S_ANG   = 5'd13;
  localparam logic [4:0] S_CW0   = 5'd14;
  localparam logic [4:0] S_CR0   = 5'd15;
  localparam logic [4:0] S_HNEXT = 5'd16;
  localparam logic [4:0] S_HMUL  = 5'd17;
  localparam logic [4:0] S_DIVI  = 5'd18;
  localparam logic [4:0] S_DIV   = 5'd19;
  localparam logic [4:0] S_DIVF  = 5'd20;
  localparam logic [4:0] S_MV    = 5'd21;
  localparam logic [4:0] S_MVW   = 5'd22;
  localparam logic [4:0] S_MUW   = 5'd23;
  localparam logic [4:0] S_MRC   = 5'd24;
  localparam logic [4:0] S_MRD   = 5'd25;
  localparam logic [4:0] S_MCE   = 5'd26;
  localparam logic [4:0] S_OUT   = 5'd27;

  // Stores
  logic signed [47:0] t_mem [0:T_ENTRIES-1];
  logic signed [47:0] c_mem [0:MAX_POLY_TERMS-1];
  logic [3:0]         t_addr_r;
  logic signed [47:0] t_rdata_r;
  logic [CA_W-1:0]    c_addr_r;
  logic signed [47:0] c_rdata_r;

  // Control
  logic [4:0]         st_r;
  logic [1:0]         r_r;
  logic [1:0]         k_r;
  logic [4:0]         i_r;
  logic [5:0]         dcnt_r;
  logic               dsel_r;
  logic [CNT_W-1:0]   hk_r;

  // Datapath
  logic signed [31:0] px_r, py_r, pz_r;
  logic [7:0]         pr_r, pg_r, pb_r;
  logic signed [63:0] acc_r;
  logic signed [31:0] cam_r [0:2];
  logic [63:0]        sn_r;
  logic [63:0]        sres_r;
  logic [31:0]        normv_r;
  logic [31:0]        ne_r;
  logic signed [63:0] cx_r, cy_r;
  logic signed [31:0] zc_r;
  logic signed [31:0] theta_r;
  logic signed [47:0] rho_r;
  logic [61:0]        dnum_r;
  logic [32:0]        drem_r;
  logic               dneg_r;
  logic signed [63:0] rz_r, ry_r, v_r, u_r, t1_r;
  logic signed [63:0] rowacc_r, colacc_r;

  // Output register
  logic               out_valid_r;
  logic signed [31:0] row_r, col_r, ox_r, oy_r, oz_r;
  logic [7:0]         or_r, og_r, ob_r;

  // Combinational helpers
  logic               t_we, c_we;
  logic signed [31:0] p_sel;
  logic [63:0]        sbit, strial;
  logic [63:0]        sn_nxt, sres_nxt;
  logic [63:0]        cmx;
  logic signed [63:0] cdx, cdy;
  logic signed [31:0] at_ext;
  logic [30:0]        ang;
  logic [30:0]        ang_cmp;
  logic [CNT_W-1:0]   n_terms;
  logic [32:0]        rsh;
  logic               dge;
  logic signed [31:0] dsrc;
  logic [31:0]        dmag;
  logic signed [63:0] dq;
  logic               out_free;

  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign t_we  = q_pop && (q_head.op == OP_LOAD_T);
  assign c_we  = q_pop && (q_head.op == OP_LOAD_C);

  // Transform store
  always_ff @(posedge clk) begin
    if (t_we) t_mem[q_head.idx] <= q_head.value;
    t_rdata_r <= t_mem[t_addr_r];
  end

  // Coefficient store
  always_ff @(posedge clk) begin
    if (c_we) c_mem[CA_W'(q_head.idx)] <= q_head.value;
    c_rdata_r <= c_mem[c_addr_r];
  end

  // Point coordinate for the current transform column
  always_comb begin
    case (k_r)
      2'd0:    p_sel = px_r;
      2'd1:    p_sel = py_r;
      default: p_sel = pz_r;
    endcase
  end

  // Square root step, one result bit per pair of input bits
  assign sbit   = 64'h4000_0000_0000_0000 >> {i_r, 1'b0};
  assign strial = sres_r + sbit;
  always_comb begin
    if (sn_r >= strial) begin
      sn_nxt   = sn_r - strial;
      sres_nxt = (sres_r >> 1) + sbit;
    end else begin
      sn_nxt   = sn_r;
      sres_nxt = sres_r >> 1;
    end
  end

  // CORDIC vectoring step
  assign cmx    = (cx_r > cy_r) ? cx_r : cy_r;
  assign cdx    = cy_r >>> i_r;
  assign cdy    = cx_r >>> i_r;
  assign at_ext = {3'd0, atan_entry(i_r)};

  // Angle clamp to [0, pi/2]
  always_comb begin
    if (zc_r < 0) ang = '0;
    else if (zc_r > $signed({1'b0, HALF_PI_Q29})) ang = HALF_PI_Q29;
    else ang = zc_r[30:0];
  end
  assign ang_cmp = (normv_r == '0) ? '0 : ang;

  assign n_terms = ({27'd0, cfg.poly_terms} > 32'(MAX_POLY_TERMS)) ?
                   CNT_W'(MAX_POLY_TERMS) : CNT_W'(cfg.poly_terms);

  // Restoring divider step
  assign rsh  = {drem_r[31:0], dnum_r[61]};
  assign dge  = rsh >= {1'b0, ne_r};
  assign dsrc = dsel_r ? cam_r[1] : cam_r[2];
  assign dmag = dsrc[31] ? 32'(-dsrc) : 32'(dsrc);
  assign dq   = dneg_r ? -$signed({2'b00, dnum_r}) : $signed({2'b00, dnum_r});

  assign out_free = !out_valid_r || !out_stall;

  // Multiplier requests
  always_comb begin
    mreq = '0;
    case (st_r)
      S_TUSE: begin
        if (k_r != 2'd3) begin
          mreq.start = 1'b1;
          mreq.a     = {{16{t_rdata_r[47]}}, t_rdata_r};
          mreq.b     = {{32{p_sel[31]}}, p_sel};
          mreq.shamt = 5'd24;
        end
      end
      S_CHK: begin
        if (cam_r[0] > 0) begin
          mreq.start = 1'b1;
          mreq.a     = {{32{cam_r[1][31]}}, cam_r[1]};
          mreq.b     = {{32{cam_r[1][31]}}, cam_r[1]};
          mreq.shamt = 5'd0;
        end
      end
      S_SQY: begin
        mreq.start = mrsp.done;
        mreq.a     = {{32{cam_r[2][31]}}, cam_r[2]};
        mreq.b     = {{32{cam_r[2][31]}}, cam_r[2]};
        mreq.shamt = 5'd0;
      end
      S_HNEXT: begin
        mreq.start = (hk_r != '0);
        mreq.a     = {{16{rho_r[47]}}, rho_r};
        mreq.b     = {{32{theta_r[31]}}, theta_r};
        mreq.shamt = 5'd29;
      end
      S_MV: begin
        mreq.start = 1'b1;
        mreq.a     = rz_r;
        mreq.b     = {{16{rho_r[47]}}, rho_r};
        mreq.shamt = 5'd30;
      end
      S_MVW: begin
        mreq.start = mrsp.done;
        mreq.a     = ry_r;
        mreq.b     = {{16{rho_r[47]}}, rho_r};
        mreq.shamt = 5'd30;
      end
      S_MUW: begin
        mreq.start = mrsp.done;
        mreq.a     = v_r;
        mreq.b     = {{32{cfg.affine_c[31]}}, cfg.affine_c};
        mreq.shamt = 5'd24;
      end
      S_MRC: begin
        mreq.start = mrsp.done;
        mreq.a     = u_r;
        mreq.b     = {{32{cfg.affine_d[31]}}, cfg.affine_d};
        mreq.shamt = 5'd24;
      end
      S_MRD: begin
        mreq.start = mrsp.done;
        mreq.a     = v_r;
        mreq.b     = {{32{cfg.affine_e[31]}}, cfg.affine_e};
        mreq.shamt = 5'd24;
      end
      default: mreq = '0;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      r_r         <= '0;
      k_r         <= '0;
      i_r         <= '0;
      dcnt_r      <= '0;
      dsel_r      <= 1'b0;
      hk_r        <= '0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (q_pop && q_head.op == OP_PROJECT) begin
            px_r  <= q_head.x;
            py_r  <= q_head.y;
            pz_r  <= q_head.z;
            pr_r  <= q_head.red;
            pg_r  <= q_head.green;
            pb_r  <= q_head.blue;
            acc_r <= '0;
            r_r   <= '0;
            k_r   <= '0;
            st_r  <= S_TADDR;
          end
        end
        // Camera frame: three rows of three products plus translation
        S_TADDR: begin
          t_addr_r <= {r_r, k_r};
          st_r     <= S_TWAIT;
        end
        S_TWAIT: st_r <= S_TUSE;
        S_TUSE: begin
          if (k_r == 2'd3) begin
            acc_r <= acc_r + 64'(t_rdata_r >>> 8);
            st_r  <= S_TROW;
          end else begin
            st_r <= S_TMUL;
          end
        end
        S_TMUL: begin
          if (mrsp.done) begin
            acc_r <= acc_r + mrsp.res;
            k_r   <= k_r + 1'b1;
            st_r  <= S_TADDR;
          end
        end
        S_TROW: begin
          cam_r[r_r] <= sat32(acc_r);
          acc_r      <= '0;
          k_r        <= '0;
          if (r_r == 2'd2) st_r <= S_CHK;
          else begin
            r_r  <= r_r + 1'b1;
            st_r <= S_TADDR;
          end
        end
        // Depth test, then y^2 + z^2
        S_CHK: begin
          if (cam_r[0] > 0) st_r <= S_SQY;
          else st_r <= S_IDLE;
        end
        S_SQY: begin
          if (mrsp.done) begin
            sn_r <= mrsp.res;
            st_r <= S_SQZ;
          end
        end
        S_SQZ: begin
          if (mrsp.done) begin
            sn_r   <= sn_r + mrsp.res;
            sres_r <= '0;
            i_r    <= '0;
            st_r   <= S_SQRT;
          end
        end
        S_SQRT: begin
          sn_r   <= sn_nxt;
          sres_r <= sres_nxt;
          i_r    <= i_r + 1'b1;
          if (i_r == 5'd31) st_r <= S_NORMI;
        end
        S_NORMI: begin
          normv_r <= sres_r[31:0];
          ne_r    <= (sres_r[31:0] == '0) ? 32'd1 : sres_r[31:0];
          cx_r    <= {32'd0, cam_r[0]};
          cy_r    <= (sres_r[31:0] == '0) ? 64'sd1 : {32'd0, sres_r[31:0]};
          st_r    <= S_NORM;
        end
        // Scale up until the larger leg reaches 2^58
        S_NORM: begin
          if (cmx[63:58] == '0) begin
            cx_r <= cx_r <<< 1;
            cy_r <= cy_r <<< 1;
          end else begin
            zc_r <= '0;
            i_r  <= '0;
            st_r <= S_CORD;
          end
        end
        S_CORD: begin
          if (cy_r > 0) begin
            cx_r <= cx_r + cdx;
            cy_r <= cy_r - cdy;
            zc_r <= zc_r + at_ext;
          end else begin
            cx_r <= cx_r - cdx;
            cy_r <= cy_r + cdy;
            zc_r <= zc_r - at_ext;
          end
          i_r <= i_r + 1'b1;
          if (i_r == 5'(CORDIC_STEPS - 1)) st_r <= S_ANG;
        end
        // Field of view test, theta, first coefficient fetch
        S_ANG: begin
          theta_r  <= $signed({1'b0, ang}) - $signed({1'b0, HALF_PI_Q29});
          c_addr_r <= CA_W'(n_terms - 1'b1);
          hk_r     <= n_terms - 1'b1;
          dsel_r   <= 1'b0;
          if (ang_cmp >= cfg.half_fov) st_r <= S_IDLE;
          else if (n_terms == '0) begin
            rho_r <= '0;
            st_r  <= S_DIVI;
          end else st_r <= S_CW0;
        end
        S_CW0: st_r <= S_CR0;
        S_CR0: begin
          rho_r <= c_rdata_r;
          st_r  <= S_HNEXT;
        end
        // Horner: rho = sat(rho*theta + c[k-1])
        S_HNEXT: begin
          if (hk_r == '0) st_r <= S_DIVI;
          else begin
            c_addr_r <= CA_W'(hk_r - 1'b1);
            st_r     <= S_HMUL;
          end
        end
        S_HMUL: begin
          if (mrsp.done) begin
            rho_r <= sat48({mrsp.res[63], mrsp.res} +
                           {{17{c_rdata_r[47]}}, c_rdata_r});
            hk_r  <= hk_r - 1'b1;
            st_r  <= S_HNEXT;
          end
        end
        // -z/ne then -y/ne, Q2.30, truncated toward zero
        S_DIVI: begin
          dnum_r <= {dmag, 30'd0};
          drem_r <= '0;
          dneg_r <= ~dsrc[31];
          dcnt_r <= '0;
          st_r   <= S_DIV;
        end
        S_DIV: begin
          drem_r <= dge ? (rsh - {1'b0, ne_r}) : rsh;
          dnum_r <= {dnum_r[60:0], dge};
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == 6'd61) st_r <= S_DIVF;
        end
        S_DIVF: begin
          if (dsel_r) begin
            ry_r <= dq;
            st_r <= S_MV;
          end else begin
            rz_r   <= dq;
            dsel_r <= 1'b1;
            st_r   <= S_DIVI;
          end
        end
        // Pixel terms
        S_MV: st_r <= S_MVW;
        S_MVW: begin
          if (mrsp.done) begin
            v_r  <= mrsp.res;
            st_r <= S_MUW;
          end
        end
        S_MUW: begin
          if (mrsp.done) begin
            u_r  <= mrsp.res;
            st_r <= S_MRC;
          end
        end
        S_MRC: begin
          if (mrsp.done) begin
            t1_r <= mrsp.res;
            st_r <= S_MRD;
          end
        end
        S_MRD: begin
          if (mrsp.done) begin
            rowacc_r <= t1_r + mrsp.res + $signed({24'd0, cfg.center_row, 8'd0});
            st_r     <= S_MCE;
          end
        end
        S_MCE: begin
          if (mrsp.done) begin
            colacc_r <= mrsp.res + u_r + $signed({24'd0, cfg.center_col, 8'd0});
            st_r     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            row_r       <= sat32(rowacc_r >>> 8);
            col_r       <= sat32(colacc_r >>> 8);
            ox_r        <= px_r;
            oy_r        <= py_r;
            oz_r        <= pz_r;
            or_r        <= pr_r;
            og_r        <= pg_r;
            ob_r        <= pb_r;
            out_valid_r <= 1'b1;
            st_r        <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_row_pos = row_r;
  assign out_col_pos = col_r;
  assign out_x       = ox_r;
  assign out_y       = oy_r;
  assign out_z       = oz_r;
  assign out_red     = or_r;
  assign out_green   = og_r;
  assign out_blue    = ob_r;

  a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r) == S_OUT) else $error("result without point");

  a_cordic_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_CORD |-> i_r < 5'(CORDIC_STEPS)) else $error("CORDIC overrun");

  a_norm_fits: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_NORMI |-> sres_r[63:32] == '0) else $error("norm too wide");

  a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mrsp.done |-> (st_r == S_TMUL || st_r == S_SQY || st_r == S_SQZ ||
                   st_r == S_HMUL || st_r == S_MVW || st_r == S_MUW ||
                   st_r == S_MRC || st_r == S_MRD || st_r == S_MCE))
    else $error("multiplier result not awaited");

endmodule

[sv/fisheye_point_projector.sv]
// Top level of the fisheye point projector: register file and block wiring.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------------
//  in_      | in_valid / in_stall | func, load_index, load_value, point xyz, color
//  out_     | out_valid/out_stall | row_pos, col_pos, x, y, z, color echo
//  config   | psel/penable/pready | paddr[4:2] selects the register, pwdata
//
// Load requests are written into their store as they are popped. A kept
// point runs through the shared multi-cycle multiplier, the 62-step divider
// (run twice), the 32-step square root, CORDIC scaling and 30 CORDIC steps.
// Dropped points end after the depth or angle test. Reset is synchronous;
// stores come up unwritten. A two-entry queue decouples in_stall from
// back-end work; a full output register holds the back end in its final
// step only.
`timescale 1ns / 1ps
module fisheye_point_projector import fpp_pkg::*; #(
  parameter int MAX_POLY_TERMS = MAX_POLY_TERMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic [3:0]         in_load_index,
  input  logic signed [47:0] in_load_value,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_row_pos,
  output logic signed [31:0] out_col_pos,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t     cfg_r;
  logic     cfg_we;
  logic [2:0] reg_idx;

  logic     q_full, q_push, q_pop, q_valid;
  qent_t    q_in, q_head;
  mul_req_t mreq;
  mul_rsp_t mrsp;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_we  = psel & penable & pwrite;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_fov   <= RST_HALF_FOV;
      cfg_r.center_row <= '0;
      cfg_r.center_col <= '0;
      cfg_r.affine_c   <= RST_AFFINE_C;
      cfg_r.affine_d   <= '0;
      cfg_r.affine_e   <= '0;
      cfg_r.poly_terms <= RST_POLY_TERMS;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_HALF_FOV:   cfg_r.half_fov   <= pwdata[30:0];
        REG_CENTER_ROW: cfg_r.center_row <= pwdata;
        REG_CENTER_COL: cfg_r.center_col <= pwdata;
        REG_AFFINE_C:   cfg_r.affine_c   <= pwdata;
        REG_AFFINE_D:   cfg_r.affine_d   <= pwdata;
        REG_AFFINE_E:   cfg_r.affine_e   <= pwdata;
        REG_POLY_TERMS: cfg_r.poly_terms <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      REG_HALF_FOV:   prdata = {1'b0, cfg_r.half_fov};
      REG_CENTER_ROW: prdata = cfg_r.center_row;
      REG_CENTER_COL: prdata = cfg_r.center_col;
      REG_AFFINE_C:   prdata = cfg_r.affine_c;
      REG_AFFINE_D:   prdata = cfg_r.affine_d;
      REG_AFFINE_E:   prdata = cfg_r.affine_e;
      REG_POLY_TERMS: prdata = {27'd0, cfg_r.poly_terms};
      default:        prdata = '0;
    endcase
  end

  fpp_front #(.MAX_POLY_TERMS(MAX_POLY_TERMS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_load_index (in_load_index),
    .in_load_value (in_load_value),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_point_z    (in_point_z),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_ent         (q_in)
  );

  fpp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ent (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  fpp_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  fpp_back #(.MAX_POLY_TERMS(MAX_POLY_TERMS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .cfg         (cfg_r),
    .mreq        (mreq),
    .mrsp        (mrsp),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_row_pos (out_row_pos),
    .out_col_pos (out_col_pos),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue)
  );

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the fisheye point projector.
`timescale 1ns / 1ps
module tb_top;
  import fpp_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam longint LIM32 = 64'sh7FFFFFFF;
  localparam longint LIM48 = 64'sh7FFFFFFFFFFF;
  localparam int SETTLE_CYCLES = 1000;
  localparam int HOLD_CYCLES = 3000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 240;

  typedef struct {
    logic [1:0]         func;
    logic [3:0]         idx;
    logic signed [47:0] val;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
  } request_t;

  typedef struct {
    logic signed [31:0] row;
    logic signed [31:0] col;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_func = '0;
  logic [3:0] in_load_index = '0;
  logic signed [47:0] in_load_value = '0;
  logic signed [31:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic [7:0] in_red = '0, in_green = '0, in_blue = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_row_pos, out_col_pos, out_x, out_y, out_z;
  logic [7:0] out_red, out_green, out_blue;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  fisheye_point_projector DUT (.*);

  always #5 clk = ~clk;

  // Predictor state: stores and register copies
  longint tmat [T_ENTRIES];
  longint coef [MAX_POLY_TERMS_DEF];
  logic [30:0] m_half_fov;
  logic [31:0] m_center_row, m_center_col;
  logic signed [31:0] m_aff_c, m_aff_d, m_aff_e;
  logic [4:0] m_terms;

  request_t pending [$];
  pixel_t pixels_due [$];
  request_t on_bus;
  int errors = 0;
  bit idle_on = 1'b1;
  logic hold_trig = 1'b0;
  int hold_left = 0;

  function automatic longint sat_to(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim - 1) return -lim - 1;
    return v;
  endfunction

  // floor(a*b / 2^s), saturated to 64 bit
  function automatic longint mul_floor(longint a, longint b, int s);
    logic signed [127:0] pa, pb, p;
    pa = a;
    pb = b;
    p = (pa * pb) >>> s;
    if (p > 128'sh7FFFFFFFFFFFFFFF) return 64'sh7FFFFFFFFFFFFFFF;
    if (p < -128'sh8000000000000000) return 64'sh8000000000000000;
    return p[63:0];
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // atan2(b, a) in Q3.29 for positive a, b
  function automatic longint off_axis_angle(longint unsigned a, longint unsigned b);
    longint unsigned mx;
    int sh;
    longint x, y, z, dx, dy;
    mx = (a > b) ? a : b;
    sh = 0;
    z = 0;
    while (mx < (64'd1 << 58)) begin
      mx <<= 1;
      sh++;
    end
    x = a << sh;
    y = b << sh;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += longint'(atan_entry(i[4:0]));
      end else begin
        x -= dx;
        y += dy;
        z -= longint'(atan_entry(i[4:0]));
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(HALF_PI_Q29)) z = longint'(HALF_PI_Q29);
    return z;
  endfunction

  function automatic longint cam_axis(int row, longint p0, longint p1, longint p2);
    longint acc;
    acc = mul_floor(tmat[row*4], p0, 24) + mul_floor(tmat[row*4+1], p1, 24) +
          mul_floor(tmat[row*4+2], p2, 24) + (tmat[row*4+3] >>> 8);
    return sat_to(acc, LIM32);
  endfunction

  // Applies one request to the predictor; returns 1 when a pixel is due
  function automatic bit project(request_t q, output pixel_t px);
    longint p0, p1, p2, x, y, z, normv, ne, angle, theta, rho, ry, rz, u, v;
    longint rowv, colv, n;
    longint unsigned my, mz;
    px = '{default: '0};
    if (q.func == FUNC_LOAD_T) begin
      if (q.idx < T_ENTRIES) tmat[q.idx] = q.val;
      return 0;
    end
    if (q.func == FUNC_LOAD_C) begin
      if (q.idx < MAX_POLY_TERMS_DEF) coef[q.idx] = q.val;
      return 0;
    end
    if (q.func != FUNC_PROJECT) return 0;
    p0 = q.px;
    p1 = q.py;
    p2 = q.pz;
    x = cam_axis(0, p0, p1, p2);
    y = cam_axis(1, p0, p1, p2);
    z = cam_axis(2, p0, p1, p2);
    if (x <= 0) return 0;
    my = (y < 0) ? -y : y;
    mz = (z < 0) ? -z : z;
    normv = root_floor(my * my + mz * mz);
    ne = (normv == 0) ? 1 : normv;
    angle = off_axis_angle(x, ne);
    if (((normv == 0) ? 0 : angle) >= longint'(m_half_fov)) return 0;
    theta = angle - longint'(HALF_PI_Q29);
    // Horner evaluation with 48 bit saturation per step
    n = (m_terms > MAX_POLY_TERMS_DEF) ? MAX_POLY_TERMS_DEF : m_terms;
    rho = 0;
    if (n > 0) begin
      rho = coef[n-1];
      for (longint k = n - 1; k > 0; k--)
        rho = sat_to(mul_floor(rho, theta, 29) + coef[k-1], LIM48);
    end
    rz = (-z * (64'sd1 << 30)) / ne;
    ry = (-y * (64'sd1 << 30)) / ne;
    v = mul_floor(rz, rho, 30);
    u = mul_floor(ry, rho, 30);
    rowv = mul_floor(v, m_aff_c, 24) + mul_floor(u, m_aff_d, 24) +
           (longint'(m_center_row) <<< 8);
    colv = mul_floor(v, m_aff_e, 24) + u + (longint'(m_center_col) <<< 8);
    px.row = sat_to(rowv >>> 8, LIM32);
    px.col = sat_to(colv >>> 8, LIM32);
    px.x = q.px;
    px.y = q.py;
    px.z = q.pz;
    px.r = q.r;
    px.g = q.g;
    px.b = q.b;
    return 1;
  endfunction

  task automatic report(string field, longint got, longint want);
    errors++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
  endtask

  // Request driver
  always @(posedge clk) begin
    pixel_t px;
    bit sent, offer;
    sent = in_valid && !in_stall;
    if (rst_n) begin
      if (sent && project(on_bus, px)) pixels_due.push_back(px);
      if (!in_valid || sent) begin
        offer = pending.size() > 0 && !(idle_on && $urandom_range(99) < 21);
        if (offer) begin
          on_bus = pending.pop_front();
          in_func <= on_bus.func;
          in_load_index <= on_bus.idx;
          in_load_value <= on_bus.val;
          in_point_x <= on_bus.px;
          in_point_y <= on_bus.py;
          in_point_z <= on_bus.pz;
          in_red <= on_bus.r;
          in_green <= on_bus.g;
          in_blue <= on_bus.b;
        end
        in_valid <= offer;
      end
    end
  end

  // Long receiver hold-off counter
  always @(posedge clk) begin
    if (hold_trig) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Result monitor
  always @(posedge clk) begin
    pixel_t w;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pixels_due.size() == 0) begin
          errors++;
          $display("[%0t] pixel with none expected: row %0d col %0d", $realtime,
                   out_row_pos, out_col_pos);
        end else begin
          w = pixels_due.pop_front();
          if (out_row_pos !== w.row) report("row_pos", out_row_pos, w.row);
          if (out_col_pos !== w.col) report("col_pos", out_col_pos, w.col);
          if (out_x !== w.x) report("x", out_x, w.x);
          if (out_y !== w.y) report("y", out_y, w.y);
          if (out_z !== w.z) report("z", out_z, w.z);
          if (out_red !== w.r) report("red", out_red, w.r);
          if (out_green !== w.g) report("green", out_green, w.g);
          if (out_blue !== w.b) report("blue", out_blue, w.b);
        end
      end
      out_stall <= (hold_left > 1) || (idle_on && $urandom_range(99) < 21);
    end
  end

  function automatic request_t mk_load(logic [1:0] f, logic [3:0] i, longint v);
    request_t q;
    q = '{default: '0};
    q.func = f;
    q.idx = i;
    q.val = v[47:0];
    q.r = $urandom;
    return q;
  endfunction

  function automatic request_t mk_point(longint x, longint y, longint z);
    request_t q;
    q = '{default: '0};
    q.func = FUNC_PROJECT;
    q.px = x[31:0];
    q.py = y[31:0];
    q.pz = z[31:0];
    q.r = $urandom;
    q.g = $urandom;
    q.b = $urandom;
    q.val = {$urandom, $urandom};
    q.idx = $urandom;
    return q;
  endfunction

  function automatic longint srand(int bits);
    return longint'($urandom_range((1 << bits) - 1, 0)) - (longint'(1) << (bits - 1));
  endfunction

  // Plausible rigid transform entry: near identity rotation, modest translation
  function automatic longint sane_entry(int i);
    if (i % 4 == 3) return srand(31);
    if (i % 4 == i / 4) return (longint'(1) << 24) + srand(23);
    return srand(23);
  endfunction

  function automatic request_t rand_request();
    request_t q;
    int sel, i;
    sel = $urandom_range(99);
    if (sel < 6) begin
      i = $urandom_range(T_ENTRIES - 1);
      q = mk_load(FUNC_LOAD_T, i, sane_entry(i));
    end else if (sel < 10) begin
      i = $urandom_range(MAX_POLY_TERMS_DEF - 1);
      q = mk_load(FUNC_LOAD_C, i, (i == 0) ? srand(32) + srand(32) : srand(30));
    end else if (sel < 14) begin
      // noise: every field at random
      q = mk_point({$urandom}, {$urandom}, {$urandom});
      q.func = $urandom;
      q.val = {$urandom, $urandom};
      // keep transform entries within sane range when the noise is a transform load
      if (q.func == FUNC_LOAD_T && q.idx < T_ENTRIES) q.val = sane_entry(q.idx);
    end else if (sel < 18) begin
      q = mk_point({$urandom}, {$urandom}, {$urandom});
    end else begin
      q = mk_point($urandom_range(1 << 26, 1), srand(27), srand(27));
    end
    return q;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_HALF_FOV:   m_half_fov = data[30:0];
      REG_CENTER_ROW: m_center_row = data;
      REG_CENTER_COL: m_center_col = data;
      REG_AFFINE_C:   m_aff_c = data;
      REG_AFFINE_D:   m_aff_d = data;
      REG_AFFINE_E:   m_aff_e = data;
      REG_POLY_TERMS: m_terms = data[4:0];
      default: ;
    endcase
  endtask

  // Wait until every request is in and every pixel is out, then let dropped
  // points finish
  task automatic settle();
    while (pending.size() != 0 || in_valid || pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(int ph);
    case (ph)
      1: begin
        write_reg(REG_HALF_FOV, 32'd0);
        write_reg(REG_CENTER_ROW, 32'd0);
        write_reg(REG_CENTER_COL, 32'd0);
        write_reg(REG_AFFINE_C, 32'h80000000);
        write_reg(REG_AFFINE_D, 32'h80000000);
        write_reg(REG_AFFINE_E, 32'h80000000);
        write_reg(REG_POLY_TERMS, 32'd0);
      end
      2: begin
        write_reg(REG_HALF_FOV, 32'hFFFFFFFF);
        write_reg(REG_CENTER_ROW, 32'hFFFFFFFF);
        write_reg(REG_CENTER_COL, 32'hFFFFFFFF);
        write_reg(REG_AFFINE_C, 32'h7FFFFFFF);
        write_reg(REG_AFFINE_D, 32'h7FFFFFFF);
        write_reg(REG_AFFINE_E, 32'h7FFFFFFF);
        write_reg(REG_POLY_TERMS, 32'd31);
      end
      default: begin
        write_reg(REG_HALF_FOV, $urandom_range(1686629713, 400000000));
        write_reg(REG_CENTER_ROW, $urandom);
        write_reg(REG_CENTER_COL, $urandom);
        write_reg(REG_AFFINE_C, (32'd1 << 24) + (srand(24) & 32'hFFFFFFFF));
        write_reg(REG_AFFINE_D, srand(22) & 32'hFFFFFFFF);
        write_reg(REG_AFFINE_E, srand(22) & 32'hFFFFFFFF);
        write_reg(REG_POLY_TERMS, (ph == 5) ? 32'd16 : $urandom_range(6, 1));
      end
    endcase
  endtask

  // Stimulus sequence
  initial begin
    m_half_fov = RST_HALF_FOV;
    m_center_row = '0;
    m_center_col = '0;
    m_aff_c = RST_AFFINE_C;
    m_aff_d = '0;
    m_aff_e = '0;
    m_terms = RST_POLY_TERMS;
    foreach (tmat[i]) tmat[i] = 0;
    foreach (coef[i]) coef[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: fill both stores, then the corner cases
    for (int i = 0; i < T_ENTRIES; i++)
      pending.push_back(mk_load(FUNC_LOAD_T, i, (i % 5 == 0) ? (longint'(1) << 24) :
                                (i == 3) ? (longint'(5) << 24) : 0));
    for (int i = 0; i < MAX_POLY_TERMS_DEF; i++)
      pending.push_back(mk_load(FUNC_LOAD_C, i, (i == 0) ? -(longint'(200) << 24) :
                                (i == 15) ? 64'sh7FFFFFFFFFFF : (longint'(3) << 22)));
    pending.push_back(mk_load(FUNC_LOAD_T, 4'd15, 64'sh800000000000));
    pending.push_back(mk_load(FUNC_UNUSED, 4'd0, 64'sh7FFFFFFFFFFF));
    pending.push_back(mk_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, -32'sh80000000));
    pending.push_back(mk_point(-32'sh80000000, 0, 0));        // depth not positive
    pending.push_back(mk_point(-(longint'(5) << 16), 0, 0));  // exactly zero depth
    pending.push_back(mk_point(1 << 16, 0, 0));               // zero radial norm
    pending.push_back(mk_point(1 << 10, 1 << 28, 1 << 28));   // far off axis, still inside the field of view
    pending.push_back(mk_point(1 << 20, -(1 << 18), 1 << 17));
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      load_config(ph);
      idle_on = (ph != 3);
      if (ph == 4) begin
        @(posedge clk);
        hold_trig <= 1'b1;
        @(posedge clk);
        hold_trig <= 1'b0;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) pending.push_back(rand_request());
      settle();
    end

    if (errors == 0) begin
      $display("** fisheye_point_projector: PASSED **");
    end else begin
      $display("** fisheye_point_projector: FAILED **");
    end
    $finish;
  end

  // Run limit
  initial begin
    #100ms;
    $display("** fisheye_point_projector: FAILED **");
    $finish;
  end

endmodule
